/* rtl/udpck_pkg.sv */
// ----------------------------------------------------------------------------
// udpck_pkg
// Shared types and constants of the IPv4/UDP header checksum builder.
// ----------------------------------------------------------------------------
package udpck_pkg;

  localparam logic [15:0] MaxPayload = 16'd65507;
  localparam logic [15:0] IpHdrBytes = 16'd28;
  localparam logic [15:0] UdpHdrBytes = 16'd8;
  localparam logic [15:0] VerIhlTos = 16'h4500;
  localparam logic [7:0] Ttl = 8'd255;
  localparam logic [7:0] ProtoUdp = 8'd17;
  localparam logic [2:0] LastWord = 3'd6;

  typedef enum logic [0:0] {
    CFG_SOURCE_IP   = 1'b0,
    CFG_SOURCE_PORT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [16:0] sum;
    logic [7:0]  pad_byte;
    logic [15:0] count;
    logic        overflow;
    logic [31:0] dest_ip;
    logic [15:0] dest_port;
  } hdr_job_t;

endpackage

/* rtl/udpck_accum.sv */
// ----------------------------------------------------------------------------
// udpck_accum
// Input register and running payload sum; hands one header job per datagram.
// ----------------------------------------------------------------------------
module udpck_accum import udpck_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  payload_byte_i,
  input  logic        byte_valid_i,
  input  logic        last_byte_i,
  input  logic [31:0] dest_ip_i,
  input  logic [15:0] dest_port_i,
  output logic        job_valid_o,
  input  logic        job_ready_i,
  output hdr_job_t    job_o
);

  logic        in_vld_q;
  logic [7:0]  byte_q;
  logic        bv_q, last_q;
  logic [31:0] dip_q;
  logic [15:0] dport_q;

  logic [16:0] sum_q, sum_d;
  logic [15:0] cnt_q, cnt_d;
  logic [7:0]  pend_q, pend_d;
  logic        odd_q, odd_d, ovf_q, ovf_d;
  logic [16:0] word_sum;

  logic     job_vld_q;
  hdr_job_t job_q;
  logic     job_free, fire;

  assign job_free   = !job_vld_q || job_ready_i;
  assign in_stall_o = in_vld_q && last_q && !job_free;
  assign fire       = in_vld_q && !in_stall_o;

  assign word_sum = {1'b0, sum_q[15:0]} + {1'b0, pend_q, byte_q} + {16'd0, sum_q[16]};

  always_comb begin
    sum_d  = sum_q;
    cnt_d  = cnt_q;
    pend_d = pend_q;
    odd_d  = odd_q;
    ovf_d  = ovf_q;
    if (bv_q) begin
      if (cnt_q < MaxPayload) begin
        if (odd_q) begin
          sum_d  = {1'b0, word_sum[15:0]} + {16'd0, word_sum[16]};
          odd_d  = 1'b0;
          pend_d = 8'd0;
        end else begin
          pend_d = byte_q;
          odd_d  = 1'b1;
        end
        cnt_d = cnt_q + 16'd1;
      end else begin
        ovf_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      job_vld_q <= 1'b0;
      sum_q     <= '0;
      cnt_q     <= '0;
      pend_q    <= '0;
      odd_q     <= 1'b0;
      ovf_q     <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_vld_q <= in_valid_i;
      end
      if (fire && last_q) begin
        job_vld_q <= 1'b1;
      end else if (job_ready_i) begin
        job_vld_q <= 1'b0;
      end
      if (fire) begin
        if (last_q) begin
          sum_q  <= '0;
          cnt_q  <= '0;
          pend_q <= '0;
          odd_q  <= 1'b0;
          ovf_q  <= 1'b0;
        end else begin
          sum_q  <= sum_d;
          cnt_q  <= cnt_d;
          pend_q <= pend_d;
          odd_q  <= odd_d;
          ovf_q  <= ovf_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      byte_q  <= payload_byte_i;
      bv_q    <= byte_valid_i;
      last_q  <= last_byte_i;
      dip_q   <= dest_ip_i;
      dport_q <= dest_port_i;
    end
    if (fire && last_q) begin
      job_q.sum       <= sum_d;
      job_q.pad_byte  <= odd_d ? pend_d : 8'd0;
      job_q.count     <= cnt_d;
      job_q.overflow  <= ovf_d;
      job_q.dest_ip   <= dip_q;
      job_q.dest_port <= dport_q;
    end
  end

  assign job_valid_o = job_vld_q;
  assign job_o       = job_q;

endmodule

/* rtl/udpck_hdr_tx.sv */
// ----------------------------------------------------------------------------
// udpck_hdr_tx
// Checksum sums, folding and serial output of the seven header words.
// ----------------------------------------------------------------------------
module udpck_hdr_tx import udpck_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        job_valid_i,
  output logic        job_ready_o,
  input  hdr_job_t    job_i,
  input  logic [31:0] source_ip_i,
  input  logic [15:0] source_port_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] header_word_o,
  output logic        word_last_o,
  output logic        too_long_o
);

  logic        sum_vld_q;
  logic [20:0] ip_raw_q, udp_raw_q;
  logic [15:0] ip_len_q, udp_len_q, dport_q;
  logic [31:0] dip_q;
  logic        ovf_q;

  logic        ser_vld_q;
  logic [2:0]  idx_q;
  logic [15:0] s_ip_len_q, s_udp_len_q, s_dport_q, ip_sum_q, udp_sum_q;
  logic [31:0] s_dip_q;
  logic        s_ovf_q;

  logic [15:0] ip_len, udp_len;
  logic [20:0] ip_raw, udp_raw;
  logic [16:0] ip_f1, udp_f1;
  logic [15:0] ip_f2, udp_f2;
  logic        out_acc, ser_take, sum_take;

  assign out_acc  = ser_vld_q && !out_stall_i;
  assign ser_take = !ser_vld_q || (out_acc && idx_q == LastWord);
  assign sum_take = !sum_vld_q || ser_take;
  assign job_ready_o = sum_take;

  assign ip_len  = IpHdrBytes + job_i.count;
  assign udp_len = UdpHdrBytes + job_i.count;

  assign ip_raw = {5'd0, VerIhlTos} + {5'd0, ip_len} + {5'd0, Ttl, ProtoUdp}
                + {5'd0, source_ip_i[31:16]} + {5'd0, source_ip_i[15:0]}
                + {5'd0, job_i.dest_ip[31:16]} + {5'd0, job_i.dest_ip[15:0]};

  assign udp_raw = {4'd0, job_i.sum} + {5'd0, job_i.pad_byte, 8'd0}
                 + {5'd0, source_ip_i[31:16]} + {5'd0, source_ip_i[15:0]}
                 + {5'd0, job_i.dest_ip[31:16]} + {5'd0, job_i.dest_ip[15:0]}
                 + {13'd0, ProtoUdp} + {4'd0, udp_len, 1'b0}
                 + {5'd0, source_port_i} + {5'd0, job_i.dest_port};

  assign ip_f1  = {1'b0, ip_raw_q[15:0]} + {12'd0, ip_raw_q[20:16]};
  assign ip_f2  = ip_f1[15:0] + {15'd0, ip_f1[16]};
  assign udp_f1 = {1'b0, udp_raw_q[15:0]} + {12'd0, udp_raw_q[20:16]};
  assign udp_f2 = udp_f1[15:0] + {15'd0, udp_f1[16]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_vld_q <= 1'b0;
      ser_vld_q <= 1'b0;
      idx_q     <= '0;
    end else begin
      if (sum_take) begin
        sum_vld_q <= job_valid_i;
      end
      if (ser_take) begin
        ser_vld_q <= sum_vld_q;
        idx_q     <= '0;
      end else if (out_acc) begin
        idx_q <= idx_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_take && job_valid_i) begin
      ip_raw_q  <= ip_raw;
      udp_raw_q <= udp_raw;
      ip_len_q  <= ip_len;
      udp_len_q <= udp_len;
      dip_q     <= job_i.dest_ip;
      dport_q   <= job_i.dest_port;
      ovf_q     <= job_i.overflow;
    end
    if (ser_take && sum_vld_q) begin
      s_ip_len_q  <= ip_len_q;
      s_udp_len_q <= udp_len_q;
      s_dip_q     <= dip_q;
      s_dport_q   <= dport_q;
      s_ovf_q     <= ovf_q;
      ip_sum_q    <= ~ip_f2;
      udp_sum_q   <= ~udp_f2;
    end
  end

  always_comb begin
    unique case (idx_q)
      3'd0:    header_word_o = {VerIhlTos, s_ip_len_q};
      3'd1:    header_word_o = 32'd0;
      3'd2:    header_word_o = {Ttl, ProtoUdp, ip_sum_q};
      3'd3:    header_word_o = source_ip_i;
      3'd4:    header_word_o = s_dip_q;
      3'd5:    header_word_o = {source_port_i, s_dport_q};
      default: header_word_o = {s_udp_len_q, udp_sum_q};
    endcase
  end

  assign out_valid_o = ser_vld_q;
  assign word_last_o = (idx_q == LastWord);
  assign too_long_o  = s_ovf_q;

endmodule

/* rtl/udp_ipv4_header_checksum_builder_core.sv */
// ----------------------------------------------------------------------------
// udp_ipv4_header_checksum_builder_core
// Builds an IPv4/UDP header with both checksums from a byte-wide payload.
// ----------------------------------------------------------------------------
// Payload bytes enter on the input channel, one item per cycle unless
// stalled, with last_byte_i set on the final item; byte_valid_i low on it
// marks an empty tail. dest_ip_i and dest_port_i come from the last item.
// Source address and port come from two registers on the always-ready
// configuration port; write it only while the block is idle, unenforced.
// Each datagram yields seven 32-bit header words on the output channel,
// one per cycle unless stalled, with word_last_o on the seventh and
// too_long_o on all of them when more than the maximum payload was
// offered. A last item passes the job, sum and serializer registers.
// Bytes of the next datagram are taken at one per cycle while a header is
// still being sent; a further last item waits while the header stages are
// full. Output stall holds the current word and backs up to the input.
// Reset clears the sums, counters, source registers and all valid flags.
// ----------------------------------------------------------------------------
module udp_ipv4_header_checksum_builder_core import udpck_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  payload_byte_i,
  input  logic        byte_valid_i,
  input  logic        last_byte_i,
  input  logic [31:0] dest_ip_i,
  input  logic [15:0] dest_port_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] header_word_o,
  output logic        word_last_o,
  output logic        too_long_o
);

  logic [31:0] source_ip_q;
  logic [15:0] source_port_q;
  logic        job_valid, job_ready;
  hdr_job_t    job;
  cfg_reg_e    cfg_sel;

  assign cfg_ready_o = 1'b1;
  assign cfg_sel     = cfg_reg_e'(cfg_index_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      source_ip_q   <= '0;
      source_port_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_sel)
        CFG_SOURCE_IP:   source_ip_q <= cfg_data_i;
        CFG_SOURCE_PORT: source_port_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  udpck_accum u_accum (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .payload_byte_i (payload_byte_i),
    .byte_valid_i   (byte_valid_i),
    .last_byte_i    (last_byte_i),
    .dest_ip_i      (dest_ip_i),
    .dest_port_i    (dest_port_i),
    .job_valid_o    (job_valid),
    .job_ready_i    (job_ready),
    .job_o          (job)
  );

  udpck_hdr_tx u_hdr_tx (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_valid_i   (job_valid),
    .job_ready_o   (job_ready),
    .job_i         (job),
    .source_ip_i   (source_ip_q),
    .source_port_i (source_port_q),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .header_word_o (header_word_o),
    .word_last_o   (word_last_o),
    .too_long_o    (too_long_o)
  );

endmodule

/* bench/tb_udp_ipv4_header_checksum_builder_core.sv */
// ----------------------------------------------------------------------------
// tb_udp_ipv4_header_checksum_builder_core
// Self-checking testbench for the IPv4/UDP header checksum builder.
// ----------------------------------------------------------------------------
// Payload bytes are sent as items on the input channel while a local model
// of the header builder tracks the running sum, the byte count and the
// overflow flag. Every last item queues the seven expected header words,
// which, with their last and too_long flags, are compared with the output
// channel. Both channels idle at random, and the source registers are swept
// through their extremes between datagrams.
// ----------------------------------------------------------------------------
module tb_udp_ipv4_header_checksum_builder_core import udpck_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [31:0] word;
    logic        last;
    logic        too_long;
  } hdr_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  cfg_reg_e    cfg_index_i = CFG_SOURCE_IP;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  payload_byte_i = '0;
  logic        byte_valid_i = 1'b0;
  logic        last_byte_i = 1'b0;
  logic [31:0] dest_ip_i = '0;
  logic [15:0] dest_port_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] header_word_o;
  logic        word_last_o;
  logic        too_long_o;

  hdr_word_t   pending_words[$];
  hdr_word_t   head_word;
  int unsigned fail_count = 0;
  int unsigned sent_items = 0;
  bit          idle_on = 1'b1;

  logic [31:0] cfg_src_ip = '0;
  logic [15:0] cfg_src_port = '0;
  bit   [31:0] acc_sum = '0;
  bit   [15:0] byte_count = '0;
  bit   [7:0]  held_byte = '0;
  bit          half_word = 1'b0;
  bit          overflowed = 1'b0;

  udp_ipv4_header_checksum_builder_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .payload_byte_i(payload_byte_i),
    .byte_valid_i  (byte_valid_i),
    .last_byte_i   (last_byte_i),
    .dest_ip_i     (dest_ip_i),
    .dest_port_i   (dest_port_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .header_word_o (header_word_o),
    .word_last_o   (word_last_o),
    .too_long_o    (too_long_o)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_stall_i <= idle_on && ($urandom_range(99) < 11);
  end

  function automatic bit [31:0] ones_add(bit [31:0] acc, bit [15:0] w);
    bit [31:0] s;
    s = acc + w;
    return {16'h0, s[15:0]} + {16'h0, s[31:16]};
  endfunction

  function automatic bit [15:0] ones_fold_inv(bit [31:0] acc);
    while (acc[31:16] != 16'h0) begin
      acc = {16'h0, acc[15:0]} + {16'h0, acc[31:16]};
    end
    return ~acc[15:0];
  endfunction

  task automatic absorb_item(input logic [7:0] b, input logic bv, input logic lst,
                             input logic [31:0] dip, input logic [15:0] dport);
    bit [31:0] payload_acc;
    bit [31:0] ip_acc;
    bit [15:0] ip_len;
    bit [15:0] udp_len;
    bit [15:0] ip_csum;
    bit [15:0] udp_csum;
    logic [31:0] words[7];
    hdr_word_t hw;
    if (bv) begin
      if (byte_count < MaxPayload) begin
        if (half_word) begin
          acc_sum = ones_add(acc_sum, {held_byte, b});
          half_word = 1'b0;
          held_byte = '0;
        end else begin
          held_byte = b;
          half_word = 1'b1;
        end
        byte_count = byte_count + 16'd1;
      end else begin
        overflowed = 1'b1;
      end
    end
    if (lst) begin
      payload_acc = acc_sum;
      if (half_word) begin
        payload_acc = ones_add(payload_acc, {held_byte, 8'h00});
      end
      ip_len = IpHdrBytes + byte_count;
      udp_len = UdpHdrBytes + byte_count;
      ip_acc = ones_add(32'h0, VerIhlTos);
      ip_acc = ones_add(ip_acc, ip_len);
      ip_acc = ones_add(ip_acc, {Ttl, ProtoUdp});
      ip_acc = ones_add(ip_acc, cfg_src_ip[31:16]);
      ip_acc = ones_add(ip_acc, cfg_src_ip[15:0]);
      ip_acc = ones_add(ip_acc, dip[31:16]);
      ip_acc = ones_add(ip_acc, dip[15:0]);
      ip_csum = ones_fold_inv(ip_acc);
      payload_acc = ones_add(payload_acc, cfg_src_ip[31:16]);
      payload_acc = ones_add(payload_acc, cfg_src_ip[15:0]);
      payload_acc = ones_add(payload_acc, dip[31:16]);
      payload_acc = ones_add(payload_acc, dip[15:0]);
      payload_acc = ones_add(payload_acc, {8'h00, ProtoUdp});
      payload_acc = ones_add(payload_acc, udp_len);
      payload_acc = ones_add(payload_acc, cfg_src_port);
      payload_acc = ones_add(payload_acc, dport);
      payload_acc = ones_add(payload_acc, udp_len);
      udp_csum = ones_fold_inv(payload_acc);
      words[0] = {VerIhlTos, ip_len};
      words[1] = 32'h0;
      words[2] = {Ttl, ProtoUdp, ip_csum};
      words[3] = cfg_src_ip;
      words[4] = dip;
      words[5] = {cfg_src_port, dport};
      words[6] = {udp_len, udp_csum};
      for (int k = 0; k < 7; k++) begin
        hw.word = words[k];
        hw.last = (k == int'(LastWord));
        hw.too_long = overflowed;
        pending_words.push_back(hw);
      end
      acc_sum = '0;
      byte_count = '0;
      held_byte = '0;
      half_word = 1'b0;
      overflowed = 1'b0;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_words.size() == 0) begin
        $error("header_word arrived with nothing expected: actual %h", header_word_o);
        fail_count++;
      end else begin
        head_word = pending_words.pop_front();
        if (header_word_o !== head_word.word) begin
          $error("header_word expected %h actual %h", head_word.word, header_word_o);
          fail_count++;
        end
        if (word_last_o !== head_word.last) begin
          $error("word_last expected %b actual %b", head_word.last, word_last_o);
          fail_count++;
        end
        if (too_long_o !== head_word.too_long) begin
          $error("too_long expected %b actual %b", head_word.too_long, too_long_o);
          fail_count++;
        end
      end
    end
  end

  task automatic push_item(input logic [7:0] b, input logic bv, input logic lst,
                           input logic [31:0] dip, input logic [15:0] dport);
    while (idle_on && $urandom_range(99) < 11) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    payload_byte_i <= b;
    byte_valid_i <= bv;
    last_byte_i <= lst;
    dest_ip_i <= dip;
    dest_port_i <= dport;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
    absorb_item(b, bv, lst, dip, dport);
    if (bv || lst) begin
      sent_items++;
    end
  endtask

  task automatic send_datagram(input int unsigned n_bytes, input bit empty_tail,
                               input int unsigned noise_pct,
                               input logic [31:0] dip, input logic [15:0] dport);
    for (int unsigned i = 0; i < n_bytes; i++) begin
      if ($urandom_range(99) < noise_pct) begin
        push_item(8'($urandom_range(255)), 1'b0, 1'b0, $urandom(),
                  16'($urandom_range(65535)));
      end
      push_item(8'($urandom_range(255)), 1'b1, (i == n_bytes - 1) && !empty_tail,
                dip, dport);
    end
    if (n_bytes == 0 || empty_tail) begin
      push_item(8'($urandom_range(255)), 1'b0, 1'b1, dip, dport);
    end
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do begin
      @(posedge clk_i);
    end while (pending_words.size() != 0);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [31:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) begin
      @(posedge clk_i);
    end
    if (idx == CFG_SOURCE_IP) begin
      cfg_src_ip = value;
    end else begin
      cfg_src_port = value[15:0];
    end
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic test_directed();
    push_item(8'h00, 1'b0, 1'b1, 32'h0, 16'h0);
    push_item(8'hff, 1'b1, 1'b0, 32'h0, 16'h0);
    push_item(8'hda, 1'b1, 1'b1, 32'h0, 16'h0);
    push_item(8'hff, 1'b1, 1'b1, 32'hffff_ffff, 16'hffff);
    push_item(8'h00, 1'b1, 1'b0, 32'h1234_5678, 16'h0101);
    push_item(8'h5a, 1'b0, 1'b0, 32'hffff_ffff, 16'hffff);
    push_item(8'h80, 1'b1, 1'b0, 32'h0, 16'h0);
    push_item(8'h7f, 1'b1, 1'b0, 32'h0, 16'h0);
    push_item(8'ha5, 1'b0, 1'b1, 32'hc0a8_0001, 16'd53);
    wait_idle();
    write_reg(CFG_SOURCE_IP, 32'hffff_ffff);
    write_reg(CFG_SOURCE_PORT, 32'hffff_ffff);
    push_item(8'hff, 1'b1, 1'b0, 32'hffff_ffff, 16'hffff);
    push_item(8'hff, 1'b1, 1'b0, 32'hffff_ffff, 16'hffff);
    push_item(8'hff, 1'b1, 1'b1, 32'hffff_ffff, 16'hffff);
    push_item(8'h00, 1'b1, 1'b1, 32'h0, 16'h0);
    wait_idle();
  endtask

  task automatic test_config_sweep();
    logic [31:0] ips[5];
    logic [31:0] ports[5];
    ips = '{32'h0, 32'hffff_ffff, 32'h8000_0001, $urandom(), $urandom()};
    ports = '{32'h0, 32'h0000_ffff, 32'hffff_8000, $urandom(), $urandom()};
    for (int s = 0; s < 5; s++) begin
      wait_idle();
      write_reg(CFG_SOURCE_IP, ips[s]);
      write_reg(CFG_SOURCE_PORT, ports[s]);
      for (int d = 0; d < 3; d++) begin
        send_datagram($urandom_range(0, 12), $urandom_range(5) == 0, 5, $urandom(),
                      16'($urandom_range(65535)));
      end
    end
    wait_idle();
  endtask

  task automatic test_back_to_back();
    idle_on = 1'b0;
    for (int d = 0; d < 20; d++) begin
      send_datagram($urandom_range(0, 10), 1'b0, 0, $urandom(),
                    16'($urandom_range(65535)));
    end
    wait_idle();
    idle_on = 1'b1;
  endtask

  task automatic test_random();
    int unsigned len;
    logic [31:0] dip;
    logic [15:0] dport;
    while (sent_items < 450) begin
      if ($urandom_range(7) == 0) begin
        wait_idle();
        write_reg(CFG_SOURCE_IP, ($urandom_range(3) == 0) ? 32'hffff_ffff : $urandom());
        write_reg(CFG_SOURCE_PORT, ($urandom_range(3) == 0) ? 32'h0 : $urandom());
      end
      len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
      dip = ($urandom_range(9) == 0) ? 32'hffff_ffff : $urandom();
      dport = ($urandom_range(9) == 0) ? 16'h0 : 16'($urandom_range(65535));
      send_datagram(len, $urandom_range(5) == 0, 5, dip, dport);
    end
    wait_idle();
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_config_sweep();
    test_back_to_back();
    test_random();
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
